// ===== hw/rtl/ppor_pkg.sv =====
package ppor_pkg;

   localparam int POS_W   = 22;             // position width, Q13.8
   localparam int RAD_W   = 16;             // radius register width
   localparam int CON_W   = RAD_W + 1;      // contact distance width
   localparam int DIF_W   = POS_W + 1;      // signed difference width
   localparam int MAG_W   = POS_W;          // magnitude of a difference
   localparam int SQ_W    = 2 * MAG_W;      // one squared component
   localparam int D2_W    = SQ_W + 1;       // squared length
   localparam int CC_W    = 2 * CON_W;      // squared contact distance
   localparam int ROOT_W  = CON_W;          // distance, only needed below contact
   localparam int REM_W   = CC_W + 1;       // square root and divider remainders
   localparam int DIV_W   = ROOT_W + 1;     // divisor, twice the distance
   localparam int QUO_W   = ROOT_W;         // push magnitude
   localparam int NSTAGE  = ROOT_W + QUO_W + 2;
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd2560;
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_NONE       = 2'd0,
      ST_RESOLVED   = 2'd1,
      ST_COINCIDENT = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [POS_W-1:0] ax;
      logic signed [POS_W-1:0] ay;
      logic signed [POS_W-1:0] bx;
      logic signed [POS_W-1:0] by;
      logic signed [DIF_W-1:0] dx;
      logic signed [DIF_W-1:0] dy;
      logic [CC_W-1:0]         d2;
      logic [CON_W-1:0]        contact;
      status_type              status;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hw/rtl/ppor_if.sv =====
interface ppor_req_if;
   import ppor_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] first_x;
   logic signed [POS_W-1:0] first_y;
   logic signed [POS_W-1:0] second_x;
   logic signed [POS_W-1:0] second_y;
   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface ppor_rsp_if;
   import ppor_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] new_first_x;
   logic signed [POS_W-1:0] new_first_y;
   logic signed [POS_W-1:0] new_second_x;
   logic signed [POS_W-1:0] new_second_y;
   status_type              contact_status;
   modport source (output valid, new_first_x, new_first_y, new_second_x, new_second_y,
                   contact_status, input ready);
   modport sink (input valid, new_first_x, new_first_y, new_second_x, new_second_y,
                 contact_status, output ready);
endinterface

// ===== hw/rtl/ppor_front.sv =====
module ppor_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ppor_pkg::RAD_W-1:0] radius,
   ppor_req_if.sink                  req,
   output logic                      push,
   output ppor_pkg::item_type        push_item,
   input  logic                      push_ok
);
   import ppor_pkg::*;

   logic                    adv;
   logic                    v1_ff, v2_ff;
   logic signed [POS_W-1:0] ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic signed [POS_W-1:0] ax2_ff, ay2_ff, bx2_ff, by2_ff;
   logic signed [DIF_W-1:0] dx1_in, dy1_in, dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic [CON_W-1:0]        con1_in, con1_ff, con2_ff;
   logic [CC_W-1:0]         cc2_ff;
   logic [DIF_W-1:0]        absx, absy;
   logic [MAG_W-1:0]        magx, magy;
   logic [SQ_W-1:0]         sqx2_ff, sqy2_ff;
   logic [D2_W-1:0]         d2;
   logic                    overlap;

   assign adv       = !v2_ff || push_ok;
   assign req.ready = adv;

   assign dx1_in  = DIF_W'(req.first_x) - DIF_W'(req.second_x);
   assign dy1_in  = DIF_W'(req.first_y) - DIF_W'(req.second_y);
   assign con1_in = {radius, 1'b0};

   assign absx = dx1_ff[DIF_W-1] ? DIF_W'(-dx1_ff) : DIF_W'(dx1_ff);
   assign absy = dy1_ff[DIF_W-1] ? DIF_W'(-dy1_ff) : DIF_W'(dy1_ff);
   assign magx = absx[MAG_W-1:0];
   assign magy = absy[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax1_ff  <= req.first_x;
         ay1_ff  <= req.first_y;
         bx1_ff  <= req.second_x;
         by1_ff  <= req.second_y;
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         con1_ff <= con1_in;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         bx2_ff  <= bx1_ff;
         by2_ff  <= by1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         con2_ff <= con1_ff;
         cc2_ff  <= con1_ff * con1_ff;
         sqx2_ff <= magx * magx;
         sqy2_ff <= magy * magy;
      end
   end

   // Squared length against squared contact distance, both exact.
   assign d2      = D2_W'(sqx2_ff) + D2_W'(sqy2_ff);
   assign overlap = d2 < D2_W'(cc2_ff);

   always_comb begin
      push_item.ax      = ax2_ff;
      push_item.ay      = ay2_ff;
      push_item.bx      = bx2_ff;
      push_item.by      = by2_ff;
      push_item.dx      = dx2_ff;
      push_item.dy      = dy2_ff;
      push_item.d2      = d2[CC_W-1:0];
      push_item.contact = con2_ff;
      if (!overlap) begin
         push_item.status = ST_NONE;
      end else if (d2 == '0) begin
         push_item.status = ST_COINCIDENT;
      end else begin
         push_item.status = ST_RESOLVED;
      end
   end

   assign push = v2_ff && push_ok;

endmodule

// ===== hw/rtl/ppor_queue.sv =====
module ppor_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ppor_pkg::item_type   push_item,
   input  logic                 pop,
   output ppor_pkg::item_type   pop_item,
   output ppor_pkg::q_stat_type stat
);
   import ppor_pkg::*;

   item_type        mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]   cnt_ff, cnt_in;

   assign stat.full  = cnt_ff == (Q_AW+1)'(Q_DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/ppor_back.sv =====
module ppor_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ppor_pkg::q_stat_type q_stat,
   output logic                 pop,
   input  ppor_pkg::item_type   pop_item,
   ppor_rsp_if.source           rsp
);
   import ppor_pkg::*;

   typedef struct packed {
      item_type          it;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
      logic [REM_W-1:0]  rx;
      logic [REM_W-1:0]  ry;
      logic [QUO_W-1:0]  qx;
      logic [QUO_W-1:0]  qy;
   } stage_type;

   stage_type               stg_ff [NSTAGE];
   stage_type               stg_in [NSTAGE];
   logic [NSTAGE-1:0]       vld_ff;
   logic                    adv;
   logic                    rsp_v_ff;
   logic signed [POS_W-1:0] nfx_ff, nfy_ff, nsx_ff, nsy_ff;
   logic signed [POS_W-1:0] nfx_in, nfy_in, nsx_in, nsy_in;
   status_type              st_ff;

   // One root bit per stage, most significant first.
   function automatic stage_type sqrt_step(stage_type st, int k);
      stage_type        r;
      logic [REM_W-1:0] t;
      r = st;
      t = (REM_W'(st.root) << (k + 1)) | (REM_W'(1) << (2 * k));
      if (st.rem >= t) begin
         r.rem  = st.rem - t;
         r.root = st.root | (ROOT_W'(1) << k);
      end
      return r;
   endfunction

   // Overlap times each magnitude, plus the distance so the quotient rounds.
   function automatic stage_type mul_step(stage_type st);
      stage_type           r;
      logic [CON_W-1:0]    delta;
      logic [DIF_W-1:0]    absx, absy;
      logic [ROOT_W-1:0]   magx, magy;
      logic [2*ROOT_W-1:0] px, py;
      r     = st;
      delta = st.it.contact - st.root;
      absx  = st.it.dx[DIF_W-1] ? DIF_W'(-st.it.dx) : DIF_W'(st.it.dx);
      absy  = st.it.dy[DIF_W-1] ? DIF_W'(-st.it.dy) : DIF_W'(st.it.dy);
      magx  = absx[ROOT_W-1:0];
      magy  = absy[ROOT_W-1:0];
      px    = delta * magx;
      py    = delta * magy;
      r.rx  = REM_W'(px) + REM_W'(st.root);
      r.ry  = REM_W'(py) + REM_W'(st.root);
      r.qx  = '0;
      r.qy  = '0;
      return r;
   endfunction

   // One quotient bit per stage for both axes, divisor is twice the distance.
   function automatic stage_type div_step(stage_type st, int k);
      stage_type        r;
      logic [DIV_W-1:0] dv;
      logic [REM_W-1:0] t;
      r  = st;
      dv = {st.root, 1'b0};
      t  = REM_W'(dv) << k;
      if (st.rx >= t) begin
         r.rx    = st.rx - t;
         r.qx[k] = 1'b1;
      end
      if (st.ry >= t) begin
         r.ry    = st.ry - t;
         r.qy[k] = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] sat(logic signed [POS_W+1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > (POS_W+2)'(POS_MAX)) begin
         r = POS_MAX;
      end else if (v < (POS_W+2)'(POS_MIN)) begin
         r = POS_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   assign adv = !rsp_v_ff || rsp.ready;
   assign pop = adv && !q_stat.empty;

   always_comb begin
      stg_in[0]      = '0;
      stg_in[0].it   = pop_item;
      stg_in[0].rem  = REM_W'(pop_item.d2);
      for (int s = 0; s < ROOT_W; s++) begin
         stg_in[s+1] = sqrt_step(stg_ff[s], ROOT_W - 1 - s);
      end
      stg_in[ROOT_W+1] = mul_step(stg_ff[ROOT_W]);
      for (int j = 0; j < QUO_W; j++) begin
         stg_in[ROOT_W+2+j] = div_step(stg_ff[ROOT_W+1+j], QUO_W - 1 - j);
      end
   end

   always_comb begin
      logic signed [QUO_W:0]   mx, my, sx, sy;
      stage_type               ls;
      ls = stg_ff[NSTAGE-1];
      mx = signed'({1'b0, ls.qx});
      my = signed'({1'b0, ls.qy});
      sx = ls.it.dx[DIF_W-1] ? -mx : mx;
      sy = ls.it.dy[DIF_W-1] ? -my : my;
      if (ls.it.status != ST_RESOLVED) begin
         sx = '0;
         sy = '0;
      end
      nfx_in = sat((POS_W+2)'(ls.it.ax) + (POS_W+2)'(sx));
      nfy_in = sat((POS_W+2)'(ls.it.ay) + (POS_W+2)'(sy));
      nsx_in = sat((POS_W+2)'(ls.it.bx) - (POS_W+2)'(sx));
      nsy_in = sat((POS_W+2)'(ls.it.by) - (POS_W+2)'(sy));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         vld_ff   <= {vld_ff[NSTAGE-2:0], pop};
         rsp_v_ff <= vld_ff[NSTAGE-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NSTAGE; i++) begin
            stg_ff[i] <= stg_in[i];
         end
         nfx_ff <= nfx_in;
         nfy_ff <= nfy_in;
         nsx_ff <= nsx_in;
         nsy_ff <= nsy_in;
         st_ff  <= stg_ff[NSTAGE-1].it.status;
      end
   end

   assign rsp.valid          = rsp_v_ff;
   assign rsp.new_first_x    = nfx_ff;
   assign rsp.new_first_y    = nfy_ff;
   assign rsp.new_second_x   = nsx_ff;
   assign rsp.new_second_y   = nsy_ff;
   assign rsp.contact_status = st_ff;

endmodule

// ===== hw/rtl/particle_pair_overlap_resolve.sv =====
// Resolves the overlap of two equal circular particles. Each request beat carries both
// positions in signed Q13.8; each response beat returns the corrected positions (the first
// pushed forward and the second back along the unit normal by half the overlap, saturated to
// the position range) and a status: no overlap, resolved, or coincident positions left as
// they are. The block takes one pair per clock cycle while its queue is not full. A pair
// passes two classify stages, a four entry queue, seventeen square root stages (one root bit
// each), one multiply stage, seventeen divider stages (one quotient bit each for both axes)
// and the response register. The user writes the contact radius through csr_we and
// csr_wdata only while no pair is in flight; the block does not enforce this.
module particle_pair_overlap_resolve (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [ppor_pkg::RAD_W-1:0] csr_wdata,
   ppor_req_if.sink                  req_bus,
   ppor_rsp_if.source                rsp_bus
);
   import ppor_pkg::*;

   logic [RAD_W-1:0] radius_ff;
   logic             push, pop;
   item_type         push_item, pop_item;
   q_stat_type       q_stat;

   // Radius register; the contact distance is derived from it per pair.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   // The front computes differences and squared length and classifies the pair.
   ppor_front u_front (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .req       (req_bus),
      .push      (push),
      .push_item (push_item),
      .push_ok   (!q_stat.full)
   );

   // The queue lets the front keep accepting while the back is stalled by the sink.
   ppor_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   // The back takes the distance, divides out the push and saturates the result.
   ppor_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop      (pop),
      .pop_item (pop_item),
      .rsp      (rsp_bus)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full) else $error("push into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("pop from an empty queue");
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty)) else $error("queue both full and empty");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid) else $error("response valid after reset");
`endif

endmodule
